>>> sv/gdr_pkg.sv
package gdr_pkg;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_TOKEN  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic KIND_TOKEN = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    localparam logic [1:0] CFG_LOG_GATE  = 2'd0;
    localparam logic [1:0] CFG_KEY_DIM   = 2'd1;
    localparam logic [1:0] CFG_VALUE_DIM = 2'd2;

    localparam int CFG_W = 7;
    localparam int ACC_W = 64;
    localparam logic signed [17:0] LOG2E_Q16 = 18'sd94548;

    typedef struct packed {
        logic [1:0]         op;
        logic [5:0]         row;
        logic [5:0]         col;
        logic               last;
        logic signed [31:0] sval;
        logic signed [31:0] query;
        logic signed [31:0] key;
        logic signed [31:0] value;
        logic signed [31:0] decay;
        logic signed [31:0] beta;
    } cmd_t;

    typedef enum logic [1:0] {
        F_EMPTY,
        F_EXP_MUL,
        F_EXP_INTERP,
        F_PUSH
    } f_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_READ_OUT,
        B_P1,
        B_P1_DRAIN,
        B_DIFF,
        B_DELTA_MUL,
        B_DELTA,
        B_P2,
        B_P2_DRAIN,
        B_EMIT
    } b_state_t;

    function automatic logic [17:0] exp2_tab(input logic [4:0] idx);
        logic [17:0] t;
        case (idx)
            5'd0:    t = 18'd65536;
            5'd1:    t = 18'd68438;
            5'd2:    t = 18'd71468;
            5'd3:    t = 18'd74632;
            5'd4:    t = 18'd77936;
            5'd5:    t = 18'd81386;
            5'd6:    t = 18'd84990;
            5'd7:    t = 18'd88752;
            5'd8:    t = 18'd92682;
            5'd9:    t = 18'd96785;
            5'd10:   t = 18'd101070;
            5'd11:   t = 18'd105545;
            5'd12:   t = 18'd110218;
            5'd13:   t = 18'd115098;
            5'd14:   t = 18'd120194;
            5'd15:   t = 18'd125515;
            5'd16:   t = 18'd131072;
            default: t = 18'd0;
        endcase
        return t;
    endfunction

    function automatic logic signed [47:0] qrnd(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = (p + 64'sd32768) >>> 16;
        return s[47:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (x < -64'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] exp_shift(input logic [17:0] m,
                                                     input logic signed [17:0] n);
        logic [31:0] r;
        logic [17:0] nn;
        logic [4:0]  k;
        nn = -n;
        k  = nn[4:0];
        if (n >= 18'sd15)
        begin
            r = 32'h7FFFFFFF;
        end
        else if (n >= 18'sd0)
        begin
            r = 32'(m) << n[3:0];
        end
        else if (n <= -18'sd18)
        begin
            r = 32'd0;
        end
        else
        begin
            r = (32'(m) + (32'd1 << (k - 5'd1))) >> k;
        end
        return r;
    endfunction

endpackage

>>> sv/gated_delta_rule_recurrence_unit.sv
// Gated delta rule recurrence for one attention head, signed Q16.16.
// Input channel (in_valid / in_stall): one beat per load, read or token
// element. Output channel (out_valid / out_stall): result beats, with
// result_last on the final beat caused by an input.
// Configuration: cfg_write_en with cfg_index and cfg_data, written while idle.
// A load or a token element without token_last gives no beat. The front
// end takes no new element until it has pushed the last one into the
// command queue, and in log gate mode a token element first passes the
// exp table interpolation. A read gives one beat. The element with
// token_last gives value_dim_used beats, one per state row; for each row
// the single multiply-accumulate pipeline makes a decay pass and an
// update pass over the row in the state memory.
// Reset clears the control logic and sets the registers to their defaults;
// the state, key, query and value memories hold nothing until written.
// When the receiver stalls, the output beat holds, the back end waits and
// the input side stalls once the two-entry command queue fills.
module gated_delta_rule_recurrence_unit #(
    parameter int MAX_KEY_DIM   = 64,
    parameter int MAX_VALUE_DIM = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_en,
    input  logic [1:0]                cfg_index,
    input  logic [gdr_pkg::CFG_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                operation,
    input  logic [5:0]                row_index,
    input  logic [5:0]                col_index,
    input  logic signed [31:0]        state_value,
    input  logic signed [31:0]        query_elem,
    input  logic signed [31:0]        key_elem,
    input  logic signed [31:0]        value_elem,
    input  logic signed [31:0]        gate_value,
    input  logic signed [31:0]        beta_value,
    input  logic                      token_last,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      result_kind,
    output logic [5:0]                result_index,
    output logic signed [31:0]        result_value,
    output logic                      result_last
);

    localparam int KD_W = $clog2(MAX_KEY_DIM + 1);
    localparam int VCAP = (MAX_VALUE_DIM < 64) ? MAX_VALUE_DIM : 64;

    logic          log_gate_mode_reg;
    logic [6:0]    key_dim_reg;
    logic [6:0]    value_dim_reg;
    logic [KD_W-1:0] kd_eff;
    logic [6:0]    vd_eff;

    logic          push_valid;
    logic          push_ready;
    gdr_pkg::cmd_t push_cmd;
    logic          head_valid;
    gdr_pkg::cmd_t head_cmd;
    logic          pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_gate_mode_reg <= 1'b0;
            key_dim_reg       <= 7'd64;
            value_dim_reg     <= 7'd64;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                gdr_pkg::CFG_LOG_GATE:  log_gate_mode_reg <= cfg_data[0];
                gdr_pkg::CFG_KEY_DIM:   key_dim_reg       <= cfg_data[6:0];
                gdr_pkg::CFG_VALUE_DIM: value_dim_reg     <= cfg_data[6:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        if (key_dim_reg == 7'd0)
        begin
            kd_eff = KD_W'(1);
        end
        else if (int'(key_dim_reg) > MAX_KEY_DIM)
        begin
            kd_eff = KD_W'(MAX_KEY_DIM);
        end
        else
        begin
            kd_eff = KD_W'(key_dim_reg);
        end
        if (value_dim_reg == 7'd0)
        begin
            vd_eff = 7'd1;
        end
        else if (int'(value_dim_reg) > VCAP)
        begin
            vd_eff = 7'(VCAP);
        end
        else
        begin
            vd_eff = value_dim_reg;
        end
    end

    gdr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .log_gate_mode (log_gate_mode_reg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .row_index     (row_index),
        .col_index     (col_index),
        .state_value   (state_value),
        .query_elem    (query_elem),
        .key_elem      (key_elem),
        .value_elem    (value_elem),
        .gate_value    (gate_value),
        .beta_value    (beta_value),
        .token_last    (token_last),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_cmd      (push_cmd)
    );

    gdr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop)
    );

    gdr_back #(
        .MAX_KEY_DIM   (MAX_KEY_DIM),
        .MAX_VALUE_DIM (MAX_VALUE_DIM)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .kd           (kd_eff),
        .vd           (vd_eff),
        .head_valid   (head_valid),
        .head_cmd     (head_cmd),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .result_index (result_index),
        .result_value (result_value),
        .result_last  (result_last)
    );

`ifndef SYNTHESIS
    a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
        push_ready || head_valid)
        else $error("command queue full and empty at once");

    a_read_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == gdr_pkg::KIND_READ) |-> result_last)
        else $error("read beat without last mark");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == gdr_pkg::KIND_TOKEN) |-> (7'(result_index) < vd_eff))
        else $error("token output row beyond value rows in use");
`endif

endmodule

>>> sv/gdr_ram.sv
module gdr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/gdr_front.sv
module gdr_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               log_gate_mode,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         operation,
    input  logic [5:0]         row_index,
    input  logic [5:0]         col_index,
    input  logic signed [31:0] state_value,
    input  logic signed [31:0] query_elem,
    input  logic signed [31:0] key_elem,
    input  logic signed [31:0] value_elem,
    input  logic signed [31:0] gate_value,
    input  logic signed [31:0] beta_value,
    input  logic               token_last,
    output logic               push_valid,
    input  logic               push_ready,
    output gdr_pkg::cmd_t      push_cmd
);

    gdr_pkg::f_state_t  state_reg, state_next;
    gdr_pkg::cmd_t      item_reg;
    logic               use_exp_reg;
    logic signed [33:0] y_reg;
    logic [17:0]        m_reg;
    logic signed [17:0] n_reg;

    logic               accept;
    logic               want_exp;
    logic signed [49:0] y_prod;
    logic signed [49:0] y_rnd;
    logic [3:0]         tab_i;
    logic [17:0]        t0;
    logic [17:0]        t1;
    logic [12:0]        t_step;
    logic [24:0]        frac_prod;
    logic [24:0]        frac_rnd;

    assign accept   = in_valid && !in_stall;
    assign want_exp = (operation == gdr_pkg::OP_TOKEN) && log_gate_mode;

    assign y_prod    = item_reg.decay * gdr_pkg::LOG2E_Q16;
    assign y_rnd     = (y_prod + 50'sd32768) >>> 16;
    assign tab_i     = y_reg[15:12];
    assign t0        = gdr_pkg::exp2_tab({1'b0, tab_i});
    assign t1        = gdr_pkg::exp2_tab(5'({1'b0, tab_i}) + 5'd1);
    assign t_step    = 13'(t1 - t0);
    assign frac_prod = 25'(t_step) * 25'(y_reg[11:0]);
    assign frac_rnd  = (frac_prod + 25'd2048) >> 12;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gdr_pkg::F_EMPTY:
            begin
                if (accept && operation != gdr_pkg::OP_UNUSED)
                begin
                    state_next = want_exp ? gdr_pkg::F_EXP_MUL : gdr_pkg::F_PUSH;
                end
            end
            gdr_pkg::F_EXP_MUL:    state_next = gdr_pkg::F_EXP_INTERP;
            gdr_pkg::F_EXP_INTERP: state_next = gdr_pkg::F_PUSH;
            gdr_pkg::F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = gdr_pkg::F_EMPTY;
                end
            end
            default: state_next = gdr_pkg::F_EMPTY;
        endcase
    end

    always_comb
    begin
        in_stall   = (state_reg != gdr_pkg::F_EMPTY);
        push_valid = (state_reg == gdr_pkg::F_PUSH);
        push_cmd   = item_reg;
        if (use_exp_reg)
        begin
            push_cmd.decay = gdr_pkg::exp_shift(m_reg, n_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gdr_pkg::F_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.op    <= operation;
            item_reg.row   <= row_index;
            item_reg.col   <= col_index;
            item_reg.last  <= token_last;
            item_reg.sval  <= state_value;
            item_reg.query <= query_elem;
            item_reg.key   <= key_elem;
            item_reg.value <= value_elem;
            item_reg.decay <= gate_value;
            item_reg.beta  <= beta_value;
            use_exp_reg    <= want_exp;
        end
        if (state_reg == gdr_pkg::F_EXP_MUL)
        begin
            y_reg <= y_rnd[33:0];
        end
        if (state_reg == gdr_pkg::F_EXP_INTERP)
        begin
            n_reg <= y_reg[33:16];
            m_reg <= t0 + 18'(frac_rnd);
        end
    end

endmodule

>>> sv/gdr_queue.sv
module gdr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  gdr_pkg::cmd_t push_cmd,
    output logic          head_valid,
    output gdr_pkg::cmd_t head_cmd,
    input  logic          pop
);

    gdr_pkg::cmd_t entry_reg [2];
    logic          wptr_reg;
    logic          rptr_reg;
    logic [1:0]    count_reg;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = entry_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (do_pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

>>> sv/gdr_back.sv
module gdr_back #(
    parameter int MAX_KEY_DIM   = 64,
    parameter int MAX_VALUE_DIM = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [$clog2(MAX_KEY_DIM+1)-1:0]  kd,
    input  logic [6:0]                        vd,
    input  logic                              head_valid,
    input  gdr_pkg::cmd_t                     head_cmd,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              result_kind,
    output logic [5:0]                        result_index,
    output logic signed [31:0]                result_value,
    output logic                              result_last
);

    localparam int KD_W = $clog2(MAX_KEY_DIM + 1);
    localparam int KC_W = (MAX_KEY_DIM > 1) ? $clog2(MAX_KEY_DIM) : 1;
    localparam int SDEP = MAX_KEY_DIM * MAX_VALUE_DIM;
    localparam int SA_W = (SDEP > 1) ? $clog2(SDEP) : 1;
    localparam int VCAP = (MAX_VALUE_DIM < 64) ? MAX_VALUE_DIM : 64;
    localparam int VA_W = (VCAP > 1) ? $clog2(VCAP) : 1;

    gdr_pkg::b_state_t state_reg, state_next;

    logic [5:0]                     row_reg;
    logic [KD_W-1:0]                col_reg;
    logic                           pass2_reg;
    logic signed [31:0]             decay_reg;
    logic signed [31:0]             beta_reg;
    logic signed [gdr_pkg::ACC_W-1:0] acc_reg;
    logic signed [31:0]             diff_reg;
    logic signed [63:0]             dprod_reg;
    logic signed [31:0]             delta_reg;
    logic                           v1_reg, v2_reg, v3_reg, v4_reg;
    logic [SA_W-1:0]                addr1_reg, addr2_reg, addr3_reg;
    logic signed [63:0]             mula_reg;
    logic signed [63:0]             mulb_reg;
    logic signed [31:0]             s1_reg;
    logic signed [31:0]             op2a_reg;
    logic signed [31:0]             op2b_reg;
    logic signed [31:0]             x_reg;
    logic [SA_W-1:0]                hold_addr_reg;
    logic                           rd_oor_reg;
    logic [5:0]                     rd_col_reg;

    logic                           issue;
    logic                           last_col;
    logic                           last_row;
    logic                           pipe_empty;
    logic                           slot_free;
    logic                           load_result;
    logic                           head_in_range;
    logic [SA_W-1:0]                head_addr;
    logic [SA_W-1:0]                issue_addr;
    logic                           take;

    logic                           s_we;
    logic [SA_W-1:0]                s_waddr;
    logic signed [31:0]             s_wdata;
    logic [SA_W-1:0]                s_raddr;
    logic signed [31:0]             s_rd;
    logic                           kq_we;
    logic                           v_we;
    logic signed [31:0]             k_rd;
    logic signed [31:0]             q_rd;
    logic signed [31:0]             v_rd;

    assign take          = (state_reg == gdr_pkg::B_IDLE) && head_valid;
    assign issue         = (state_reg == gdr_pkg::B_P1) || (state_reg == gdr_pkg::B_P2);
    assign last_col      = (col_reg == kd - KD_W'(1));
    assign last_row      = (7'(row_reg) + 7'd1 == vd);
    assign pipe_empty    = !(v1_reg || v2_reg || v3_reg || v4_reg);
    assign slot_free     = !out_valid || !out_stall;
    assign head_in_range = (int'(head_cmd.row) < MAX_VALUE_DIM)
                           && (int'(head_cmd.col) < MAX_KEY_DIM);
    assign head_addr     = SA_W'(head_cmd.row) * SA_W'(MAX_KEY_DIM) + SA_W'(head_cmd.col);
    assign issue_addr    = SA_W'(row_reg) * SA_W'(MAX_KEY_DIM)
                           + SA_W'(col_reg[KC_W-1:0]);
    assign load_result   = slot_free && ((state_reg == gdr_pkg::B_READ_OUT)
                                         || (state_reg == gdr_pkg::B_EMIT));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gdr_pkg::B_IDLE:
            begin
                if (head_valid)
                begin
                    if (head_cmd.op == gdr_pkg::OP_READ)
                    begin
                        state_next = gdr_pkg::B_READ_OUT;
                    end
                    else if (head_cmd.op == gdr_pkg::OP_TOKEN && head_cmd.last)
                    begin
                        state_next = gdr_pkg::B_P1;
                    end
                end
            end
            gdr_pkg::B_READ_OUT:
            begin
                if (slot_free)
                begin
                    state_next = gdr_pkg::B_IDLE;
                end
            end
            gdr_pkg::B_P1:
            begin
                if (last_col)
                begin
                    state_next = gdr_pkg::B_P1_DRAIN;
                end
            end
            gdr_pkg::B_P1_DRAIN:
            begin
                if (pipe_empty)
                begin
                    state_next = gdr_pkg::B_DIFF;
                end
            end
            gdr_pkg::B_DIFF:      state_next = gdr_pkg::B_DELTA_MUL;
            gdr_pkg::B_DELTA_MUL: state_next = gdr_pkg::B_DELTA;
            gdr_pkg::B_DELTA:     state_next = gdr_pkg::B_P2;
            gdr_pkg::B_P2:
            begin
                if (last_col)
                begin
                    state_next = gdr_pkg::B_P2_DRAIN;
                end
            end
            gdr_pkg::B_P2_DRAIN:
            begin
                if (pipe_empty)
                begin
                    state_next = gdr_pkg::B_EMIT;
                end
            end
            gdr_pkg::B_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = last_row ? gdr_pkg::B_IDLE : gdr_pkg::B_P1;
                end
            end
            default: state_next = gdr_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        pop     = (state_reg == gdr_pkg::B_IDLE);
        kq_we   = take && (head_cmd.op == gdr_pkg::OP_TOKEN)
                  && (int'(head_cmd.col) < MAX_KEY_DIM);
        v_we    = take && (head_cmd.op == gdr_pkg::OP_TOKEN) && (7'(head_cmd.col) < vd);
        s_we    = 1'b0;
        s_waddr = head_addr;
        s_wdata = head_cmd.sval;
        if (v3_reg)
        begin
            s_we    = 1'b1;
            s_waddr = addr3_reg;
            s_wdata = x_reg;
        end
        else if (take && head_cmd.op == gdr_pkg::OP_LOAD && head_in_range)
        begin
            s_we = 1'b1;
        end
        if (issue)
        begin
            s_raddr = issue_addr;
        end
        else if (take && head_cmd.op == gdr_pkg::OP_READ)
        begin
            s_raddr = head_addr;
        end
        else
        begin
            s_raddr = hold_addr_reg;
        end
    end

    gdr_ram #(.WIDTH(32), .DEPTH(SDEP)) u_state_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rd)
    );

    gdr_ram #(.WIDTH(32), .DEPTH(MAX_KEY_DIM)) u_key_ram (
        .clk   (clk),
        .we    (kq_we),
        .waddr (KC_W'(head_cmd.col)),
        .wdata (head_cmd.key),
        .raddr (col_reg[KC_W-1:0]),
        .rdata (k_rd)
    );

    gdr_ram #(.WIDTH(32), .DEPTH(MAX_KEY_DIM)) u_query_ram (
        .clk   (clk),
        .we    (kq_we),
        .waddr (KC_W'(head_cmd.col)),
        .wdata (head_cmd.query),
        .raddr (col_reg[KC_W-1:0]),
        .rdata (q_rd)
    );

    gdr_ram #(.WIDTH(32), .DEPTH(VCAP)) u_value_ram (
        .clk   (clk),
        .we    (v_we),
        .waddr (VA_W'(head_cmd.col)),
        .wdata (head_cmd.value),
        .raddr (VA_W'(row_reg)),
        .rdata (v_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gdr_pkg::B_IDLE;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            out_valid <= 1'b0;
            decay_reg <= '0;
            beta_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            if (load_result)
            begin
                out_valid <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid <= 1'b0;
            end
            if (take && head_cmd.op == gdr_pkg::OP_TOKEN)
            begin
                decay_reg <= head_cmd.decay;
                beta_reg  <= head_cmd.beta;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && head_cmd.op == gdr_pkg::OP_TOKEN)
        begin
            row_reg   <= '0;
            col_reg   <= '0;
            acc_reg   <= '0;
            pass2_reg <= 1'b0;
        end
        if (take && head_cmd.op == gdr_pkg::OP_READ)
        begin
            hold_addr_reg <= head_addr;
            rd_oor_reg    <= !head_in_range;
            rd_col_reg    <= head_cmd.col;
        end
        if (issue)
        begin
            col_reg <= col_reg + KD_W'(1);
        end
        if (state_reg == gdr_pkg::B_DIFF)
        begin
            diff_reg <= gdr_pkg::sat32(64'(v_rd) - 64'(gdr_pkg::sat32(acc_reg)));
        end
        if (state_reg == gdr_pkg::B_DELTA_MUL)
        begin
            dprod_reg <= diff_reg * beta_reg;
        end
        if (state_reg == gdr_pkg::B_DELTA)
        begin
            delta_reg <= gdr_pkg::sat32(64'(gdr_pkg::qrnd(dprod_reg)));
            col_reg   <= '0;
            acc_reg   <= '0;
            pass2_reg <= 1'b1;
        end
        if (state_reg == gdr_pkg::B_EMIT && slot_free && !last_row)
        begin
            row_reg   <= row_reg + 6'd1;
            col_reg   <= '0;
            acc_reg   <= '0;
            pass2_reg <= 1'b0;
        end

        addr1_reg <= issue_addr;
        addr2_reg <= addr1_reg;
        addr3_reg <= addr2_reg;
        if (v1_reg)
        begin
            mula_reg <= pass2_reg ? delta_reg * k_rd : s_rd * decay_reg;
            s1_reg   <= s_rd;
            op2a_reg <= pass2_reg ? q_rd : k_rd;
        end
        if (v2_reg)
        begin
            x_reg    <= pass2_reg
                        ? gdr_pkg::sat32(64'(s1_reg) + 64'(gdr_pkg::qrnd(mula_reg)))
                        : gdr_pkg::sat32(64'(gdr_pkg::qrnd(mula_reg)));
            op2b_reg <= op2a_reg;
        end
        if (v3_reg)
        begin
            mulb_reg <= x_reg * op2b_reg;
        end
        if (v4_reg)
        begin
            acc_reg <= acc_reg + 64'(gdr_pkg::qrnd(mulb_reg));
        end

        if (load_result)
        begin
            if (state_reg == gdr_pkg::B_READ_OUT)
            begin
                result_kind  <= gdr_pkg::KIND_READ;
                result_index <= rd_col_reg;
                result_value <= rd_oor_reg ? 32'sd0 : s_rd;
                result_last  <= 1'b1;
            end
            else
            begin
                result_kind  <= gdr_pkg::KIND_TOKEN;
                result_index <= row_reg;
                result_value <= gdr_pkg::sat32(acc_reg);
                result_last  <= last_row;
            end
        end
    end

endmodule

>>> sim/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIM = 64;
    localparam longint CYCLE_LIMIT = 10000000;
    localparam longint EXP2_Q16 [17] = '{65536, 68438, 71468, 74632, 77936, 81386, 84990,
        88752, 92682, 96785, 101070, 105545, 110218, 115098, 120194, 125515, 131072};

    typedef struct {
        logic               kind;
        logic [5:0]         index;
        logic signed [31:0] value;
        logic               last;
    } beat_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write_en;
    logic [1:0]                cfg_index;
    logic [gdr_pkg::CFG_W-1:0] cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic [1:0]                operation;
    logic [5:0]                row_index;
    logic [5:0]                col_index;
    logic signed [31:0]        state_value;
    logic signed [31:0]        query_elem;
    logic signed [31:0]        key_elem;
    logic signed [31:0]        value_elem;
    logic signed [31:0]        gate_value;
    logic signed [31:0]        beta_value;
    logic                      token_last;
    logic                      out_valid;
    logic                      out_stall;
    logic                      result_kind;
    logic [5:0]                result_index;
    logic signed [31:0]        result_value;
    logic                      result_last;

    logic signed [31:0]  heads[DIM*DIM];
    logic signed [31:0]  keys[DIM];
    logic signed [31:0]  queries[DIM];
    logic signed [31:0]  values[DIM];
    logic signed [31:0]  decay_now;
    logic signed [31:0]  beta_now;
    logic                log_mode;
    logic [6:0]          kd_reg;
    logic [6:0]          vd_reg;

    beat_t               pending[$];
    int                  errors;
    int                  rx_wait;
    int                  hold_left;
    bit                  calm;
    longint              cycles;

    gated_delta_rule_recurrence_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .row_index    (row_index),
        .col_index    (col_index),
        .state_value  (state_value),
        .query_elem   (query_elem),
        .key_elem     (key_elem),
        .value_elem   (value_elem),
        .gate_value   (gate_value),
        .beta_value   (beta_value),
        .token_last   (token_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .result_index (result_index),
        .result_value (result_value),
        .result_last  (result_last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic longint qmul(longint a, longint b);
        return (a * b + 32768) >>> 16;
    endfunction

    function automatic logic signed [31:0] clamp32(longint x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (x < -64'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] exp_gate(longint g);
        longint y;
        longint n;
        longint f;
        longint m;
        int     i;
        int     k;
        y = qmul(g, 94548);
        n = y >>> 16;
        f = y & 65535;
        i = int'(f >> 12);
        m = EXP2_Q16[i] + (((EXP2_Q16[i+1] - EXP2_Q16[i]) * (f & 4095) + 2048) >>> 12);
        if (n >= 15)
        begin
            return 32'sh7FFFFFFF;
        end
        if (n >= 0)
        begin
            return 32'(m << n);
        end
        if (n <= -18)
        begin
            return 32'sd0;
        end
        k = int'(-n);
        return 32'((m + (64'sd1 << (k - 1))) >>> k);
    endfunction

    function automatic int key_cols();
        return (kd_reg < 1) ? 1 : ((kd_reg > DIM) ? DIM : int'(kd_reg));
    endfunction

    function automatic int value_rows();
        return (vd_reg < 1) ? 1 : ((vd_reg > DIM) ? DIM : int'(vd_reg));
    endfunction

    task automatic step_token();
        int     kd;
        int     vd;
        longint acc;
        logic signed [31:0] mem;
        logic signed [31:0] diff;
        logic signed [31:0] delta;
        logic signed [31:0] d;
        beat_t  b;
        kd = key_cols();
        vd = value_rows();
        for (int r = 0; r < vd; r++)
        begin
            acc = 0;
            for (int c = 0; c < kd; c++)
            begin
                d = clamp32(qmul(heads[r*DIM+c], decay_now));
                heads[r*DIM+c] = d;
                acc += qmul(d, keys[c]);
            end
            mem = clamp32(acc);
            diff = clamp32(longint'(values[r]) - longint'(mem));
            delta = clamp32(qmul(diff, beta_now));
            acc = 0;
            for (int c = 0; c < kd; c++)
            begin
                d = clamp32(longint'(heads[r*DIM+c]) + qmul(delta, keys[c]));
                heads[r*DIM+c] = d;
                acc += qmul(d, queries[c]);
            end
            b.kind = gdr_pkg::KIND_TOKEN;
            b.index = 6'(r);
            b.value = clamp32(acc);
            b.last = (r + 1 == vd);
            pending.push_back(b);
        end
    endtask

    task automatic predict(gdr_pkg::cmd_t c);
        beat_t b;
        case (c.op)
            gdr_pkg::OP_LOAD:
            begin
                heads[c.row*DIM+c.col] = c.sval;
            end
            gdr_pkg::OP_READ:
            begin
                b.kind = gdr_pkg::KIND_READ;
                b.index = c.col;
                b.value = heads[c.row*DIM+c.col];
                b.last = 1'b1;
                pending.push_back(b);
            end
            gdr_pkg::OP_TOKEN:
            begin
                queries[c.col] = c.query;
                keys[c.col] = c.key;
                if (c.col < value_rows())
                begin
                    values[c.col] = c.value;
                end
                decay_now = log_mode ? exp_gate(c.decay) : c.decay;
                beta_now = c.beta;
                if (c.last)
                begin
                    step_token();
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_beat(gdr_pkg::cmd_t c);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        operation   <= c.op;
        row_index   <= c.row;
        col_index   <= c.col;
        state_value <= c.sval;
        query_elem  <= c.query;
        key_elem    <= c.key;
        value_elem  <= c.value;
        gate_value  <= c.decay;
        beta_value  <= c.beta;
        token_last  <= c.last;
        in_valid    <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        predict(c);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending.size() == 0);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [gdr_pkg::CFG_W-1:0] data);
        settle();
        cfg_index    <= idx;
        cfg_data     <= data;
        cfg_write_en <= 1'b1;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            gdr_pkg::CFG_LOG_GATE:  log_mode = data[0];
            gdr_pkg::CFG_KEY_DIM:   kd_reg = data;
            gdr_pkg::CFG_VALUE_DIM: vd_reg = data;
            default:
            begin
            end
        endcase
    endtask

    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return ($urandom_range(0, 1) == 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            2:       return 32'sd0;
            default: return $signed($urandom_range(0, 1 << 18)) - (1 << 17);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_gate();
        if ($urandom_range(0, 9) == 0)
        begin
            return rand_q();
        end
        if (log_mode)
        begin
            return -$signed($urandom_range(0, 3 << 16));
        end
        return $signed($urandom_range(40000, 70000));
    endfunction

    function automatic gdr_pkg::cmd_t blank_cmd(logic [1:0] op, int row, int col);
        gdr_pkg::cmd_t c;
        c.op = op;
        c.row = 6'(row);
        c.col = 6'(col);
        c.last = 1'b0;
        c.sval = rand_q();
        c.query = rand_q();
        c.key = rand_q();
        c.value = rand_q();
        c.decay = rand_gate();
        c.beta = rand_q();
        return c;
    endfunction

    task automatic fill_state();
        for (int r = 0; r < value_rows(); r++)
        begin
            for (int c = 0; c < key_cols(); c++)
            begin
                send_beat(blank_cmd(gdr_pkg::OP_LOAD, r, c));
            end
        end
    endtask

    task automatic send_token();
        int            n;
        gdr_pkg::cmd_t c;
        n = (key_cols() > value_rows()) ? key_cols() : value_rows();
        for (int i = 0; i < n; i++)
        begin
            c = blank_cmd(gdr_pkg::OP_TOKEN, $urandom_range(0, 63), i);
            c.last = (i == n - 1);
            send_beat(c);
        end
    endtask

    task automatic send_noise();
        gdr_pkg::cmd_t c;
        case ($urandom_range(0, 3))
            0:       c = blank_cmd(gdr_pkg::OP_LOAD, $urandom_range(0, value_rows() - 1),
                                   $urandom_range(0, key_cols() - 1));
            1:       c = blank_cmd(gdr_pkg::OP_READ, $urandom_range(0, value_rows() - 1),
                                   $urandom_range(0, key_cols() - 1));
            2:       c = blank_cmd(gdr_pkg::OP_UNUSED, $urandom_range(0, 63),
                                   $urandom_range(0, 63));
            default: c = blank_cmd(gdr_pkg::OP_LOAD, $urandom_range(0, 63),
                                   $urandom_range(0, 63));
        endcase
        c.last = 1'($urandom_range(0, 1));
        send_beat(c);
    endtask

    task automatic test_directed();
        gdr_pkg::cmd_t c;
        write_reg(gdr_pkg::CFG_LOG_GATE, 7'd0);
        write_reg(gdr_pkg::CFG_KEY_DIM, 7'd2);
        write_reg(gdr_pkg::CFG_VALUE_DIM, 7'd2);
        fill_state();
        c = blank_cmd(gdr_pkg::OP_LOAD, 63, 63);
        c.sval = 32'sh7FFFFFFF;
        send_beat(c);
        c = blank_cmd(gdr_pkg::OP_LOAD, 0, 1);
        c.sval = 32'sh80000000;
        send_beat(c);
        send_beat(blank_cmd(gdr_pkg::OP_READ, 63, 63));
        send_beat(blank_cmd(gdr_pkg::OP_READ, 0, 1));
        send_beat(blank_cmd(gdr_pkg::OP_UNUSED, 21, 42));
        c = blank_cmd(gdr_pkg::OP_TOKEN, 0, 0);
        c.query = 32'sh7FFFFFFF;
        c.key = 32'sh80000000;
        c.value = 32'sh7FFFFFFF;
        send_beat(c);
        c = blank_cmd(gdr_pkg::OP_TOKEN, 0, 1);
        c.decay = 32'sh00010000;
        c.beta = 32'sh7FFFFFFF;
        c.last = 1'b1;
        send_beat(c);
        send_token();
        send_beat(blank_cmd(gdr_pkg::OP_READ, 1, 0));
    endtask

    task automatic test_log_gate();
        gdr_pkg::cmd_t c;
        write_reg(gdr_pkg::CFG_LOG_GATE, 7'd1);
        write_reg(gdr_pkg::CFG_KEY_DIM, 7'd3);
        write_reg(gdr_pkg::CFG_VALUE_DIM, 7'd2);
        fill_state();
        send_token();
        for (int i = 0; i < 8; i++)
        begin
            c = blank_cmd(gdr_pkg::OP_TOKEN, 0, 0);
            c.decay = (i == 0) ? 32'sh7FFFFFFF : ((i == 1) ? 32'sh80000000 :
                      $signed(32'(i - 5) << 16));
            c.last = 1'b1;
            send_beat(c);
        end
    endtask

    task automatic test_dim_extremes();
        write_reg(gdr_pkg::CFG_LOG_GATE, 7'd0);
        write_reg(gdr_pkg::CFG_KEY_DIM, 7'd127);
        write_reg(gdr_pkg::CFG_VALUE_DIM, 7'd1);
        fill_state();
        send_token();
        write_reg(gdr_pkg::CFG_KEY_DIM, 7'd0);
        write_reg(gdr_pkg::CFG_VALUE_DIM, 7'd0);
        send_token();
    endtask

    task automatic test_random();
        int sent;
        for (int phase = 0; phase < 2; phase++)
        begin
            write_reg(gdr_pkg::CFG_LOG_GATE, 7'($urandom_range(0, 1)));
            write_reg(gdr_pkg::CFG_KEY_DIM, 7'($urandom_range(1, 4)));
            write_reg(gdr_pkg::CFG_VALUE_DIM, 7'($urandom_range(1, 4)));
            calm = (phase == 1);
            fill_state();
            sent = 0;
            while (sent < 15)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    send_token();
                    sent += 4;
                end
                else
                begin
                    send_noise();
                    sent++;
                end
            end
        end
        calm = 1'b0;
    endtask

    task automatic test_backpressure();
        write_reg(gdr_pkg::CFG_KEY_DIM, 7'd2);
        write_reg(gdr_pkg::CFG_VALUE_DIM, 7'd2);
        hold_left = 600;
        send_token();
        repeat (6) send_noise();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending.size() == 0);
        send_token();
        repeat (4) send_noise();
    endtask

    always @(posedge clk)
    begin
        beat_t b;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("unexpected beat: kind %0d index %0d value %0d last %0d",
                             result_kind, result_index, result_value, result_last);
                end
            end
            else
            begin
                b = pending.pop_front();
                if (result_kind !== b.kind || result_index !== b.index ||
                    result_value !== b.value || result_last !== b.last)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 b.kind, b.index, b.value, b.last, result_kind,
                                 result_index, result_value, result_last);
                    end
                end
            end
            rx_wait = calm ? 0 : $urandom_range(0, 7);
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (rx_wait > 0)
        begin
            out_stall <= 1'b1;
            rx_wait--;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        operation = '0;
        row_index = '0;
        col_index = '0;
        state_value = '0;
        query_elem = '0;
        key_elem = '0;
        value_elem = '0;
        gate_value = '0;
        beta_value = '0;
        token_last = 1'b0;
        out_stall = 1'b0;
        errors = 0;
        rx_wait = 0;
        hold_left = 0;
        calm = 1'b0;
        cycles = 0;
        decay_now = '0;
        beta_now = '0;
        log_mode = 1'b0;
        kd_reg = 7'd64;
        vd_reg = 7'd64;
        foreach (heads[i]) heads[i] = '0;
        foreach (keys[i])
        begin
            keys[i] = '0;
            queries[i] = '0;
            values[i] = '0;
        end
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_log_gate();
        test_dim_extremes();
        test_backpressure();
        test_random();
        settle();
        repeat (50) @(posedge clk);
        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

`default_nettype wire

>>> files.f
sv/gdr_pkg.sv
sv/gdr_ram.sv
sv/gdr_front.sv
sv/gdr_queue.sv
sv/gdr_back.sv
sv/gated_delta_rule_recurrence_unit.sv
sim/tb_top.sv
